// ===== design/h264dp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h264dp_pkg
// Shared types and constants of the H.264 RTP depacketizer: field widths,
// command, status and register codes, and the action record passed from
// the front end to the back end.
// ============================================================================
package h264dp_pkg;

    localparam int ADDR_BITS   = 20;
    localparam int LEN_BITS    = 16;
    localparam int STAP_SLACK  = 32;

    localparam int CMD_W       = 2;
    localparam int PLEN_W      = 16;
    localparam int DATA_W      = 8;
    localparam int POS_W       = 21;
    localparam int WIDE_W      = POS_W + 1;
    localparam int STATUS_W    = 3;
    localparam int SCL_W       = 3;
    localparam int SIZE_W      = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int STEP_W      = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [WIDE_W-1:0]    t_wide;
    typedef logic [LEN_BITS-1:0]  t_len;

    localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOST   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SETPOS = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SUCCESS     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SMALL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_START_CODE_LEN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_CAPACITY   = 2'd1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [SCL_W-1:0] SC_LEN_RESET = 3'd4;
    localparam t_pos             CAP_RESET    = 21'h100000;

    localparam logic [DATA_W-1:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [DATA_W-1:0] FU_START_BIT  = 8'h80;
    localparam logic [DATA_W-1:0] NRI_REF_BIT   = 8'h40;
    localparam logic [DATA_W-1:0] NRI_MASK      = 8'h60;
    localparam logic [DATA_W-1:0] SC_LAST_BYTE  = 8'h01;
    localparam logic [DATA_W-1:0] SC_ZERO_BYTE  = 8'h00;

    localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_STAP_A     = 5'd24;
    localparam logic [4:0] NAL_FU_A       = 5'd28;

    // One accepted item's worth of output: start code, one byte, one status
    typedef struct packed {
        t_addr                base;
        logic                 sc_en;
        logic                 sc_four;
        logic                 byte_en;
        logic [DATA_W-1:0]    data;
        logic                 st_en;
        logic [STATUS_W-1:0]  status;
        t_pos                 position;
    } t_action;

endpackage

// ===== design/h264dp_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h264dp_if
// Channel interfaces of the depacketizer: payload input, configuration
// write and result output, each with valid/ready.
// ============================================================================
interface h264dp_in_if;
    import h264dp_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic                first;
    logic                last;
    logic [PLEN_W-1:0]   payload_len;
    logic [DATA_W-1:0]   data_byte;
    logic [POS_W-1:0]    set_pos;

    modport source (output valid, cmd, first, last, payload_len, data_byte, set_pos,
                    input ready);
    modport sink   (input valid, cmd, first, last, payload_len, data_byte, set_pos,
                    output ready);
endinterface

interface h264dp_cfg_if;
    import h264dp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [POS_W-1:0]      wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink   (input valid, addr, wdata, output ready);
endinterface

interface h264dp_out_if;
    import h264dp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [ADDR_BITS-1:0]  write_addr;
    logic [DATA_W-1:0]     write_data;
    logic [STATUS_W-1:0]   status;
    logic [POS_W-1:0]      position;
    logic                  final_res;

    modport source (output valid, kind, write_addr, write_data, status, position, final_res,
                    input ready);
    modport sink   (input valid, kind, write_addr, write_data, status, position, final_res,
                    output ready);
endinterface

// ===== design/h264_rtp_depacketizer_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h264_rtp_depacketizer_unit
// H.264 RTP depacketizer: single NAL, STAP-A and FU-A payloads to an
// addressed Annex-B write stream plus one status per payload.
//
//   channel   direction  transaction
//   i_in      in         payload byte, lost notice or set position
//   i_cfg     in         register write (0 start_code_len, 1 out_capacity)
//   o_out     out        buffer write or payload status
//
// The front end parses one input transaction per cycle while the queue has
// room. The back end issues one result per cycle while o_out is ready; an item
// with n results holds it until all n are issued (start code items have up to
// six), so throughput follows the result count. Reset is synchronous; no clearing.
// An output stall fills the four-entry queue, then i_in.ready drops.
// ============================================================================
module h264_rtp_depacketizer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    h264dp_in_if.sink     i_in,
    h264dp_cfg_if.sink    i_cfg,
    h264dp_out_if.source  o_out
);
    import h264dp_pkg::*;

    logic    push;
    logic    pop;
    logic    queue_full;
    logic    head_valid;
    t_action push_data;
    t_action head;

    h264dp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_action     (push_data)
    );

    h264dp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .i_pop        (pop),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    h264dp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ===== design/h264dp_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h264dp_front
// Front end: accepts payload bytes and commands, runs the RFC 6184 parse
// state, and pushes one action record per item that produces results.
// ============================================================================
module h264dp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    h264dp_in_if.sink            i_in,
    h264dp_cfg_if.sink           i_cfg,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output h264dp_pkg::t_action  o_action
);
    import h264dp_pkg::*;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_SINGLE    = 3'd1;
    localparam logic [2:0] PH_STAP_HI   = 3'd2;
    localparam logic [2:0] PH_STAP_LO   = 3'd3;
    localparam logic [2:0] PH_STAP_DATA = 3'd4;
    localparam logic [2:0] PH_FU_HDR    = 3'd5;
    localparam logic [2:0] PH_FU_DATA   = 3'd6;
    localparam logic [2:0] PH_DONE      = 3'd7;

    logic [2:0]        r_phase, n_phase;
    t_len              r_bi, n_bi;
    t_len              r_len, n_len;
    logic [SIZE_W-1:0] r_nal, n_nal;
    logic [DATA_W-1:0] r_hdr, n_hdr;
    t_pos              r_cur, n_cur;
    t_pos              r_out_pos, n_out_pos;
    t_pos              r_sync, n_sync;
    logic              r_prev, n_prev;
    logic [SCL_W-1:0]  r_scl;
    t_pos              r_cap;

    logic              in_acc;
    logic              sc_four;
    t_pos              sc_len;
    t_pos              room;
    t_len              len_in;
    logic [4:0]        nal_type;
    logic [SIZE_W-1:0] stap_size;
    logic              small_sc;
    logic              small_stap;
    logic              do_end;
    logic              at_end;
    logic [STATUS_W-1:0] fin_st;

    assign i_in.ready  = !i_queue_full;
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && !i_queue_full;

    assign sc_four    = (r_scl >= SCL_W'(4));
    assign sc_len     = sc_four ? t_pos'(4) : t_pos'(3);
    assign room       = (r_cap >= r_out_pos) ? (r_cap - r_out_pos) : '0;
    assign len_in     = i_in.payload_len[LEN_BITS-1:0];
    assign nal_type   = i_in.data_byte[4:0];
    assign stap_size  = {r_hdr, i_in.data_byte};
    assign small_sc   = t_wide'(room) < (t_wide'(len_in) + t_wide'(sc_len));
    assign small_stap = t_wide'(room) < (t_wide'(len_in) + t_wide'(STAP_SLACK));

    always_comb begin
        n_phase   = r_phase;
        n_bi      = r_bi;
        n_len     = r_len;
        n_nal     = r_nal;
        n_hdr     = r_hdr;
        n_cur     = r_cur;
        n_out_pos = r_out_pos;
        n_sync    = r_sync;
        n_prev    = r_prev;
        o_action  = '0;
        o_action.sc_four = sc_four;
        do_end    = 1'b0;
        at_end    = 1'b0;
        fin_st    = ST_SUCCESS;

        if (in_acc) begin
            case (i_in.cmd)
                CMD_LOST: begin
                    n_phase = PH_IDLE;
                    n_prev  = 1'b1;
                end
                CMD_SETPOS: begin
                    n_phase   = PH_IDLE;
                    n_out_pos = i_in.set_pos;
                end
                CMD_BYTE: begin
                    if (i_in.first) begin
                        n_len   = len_in;
                        n_bi    = '0;
                        n_phase = PH_IDLE;
                        if (len_in < t_len'(2)) begin
                            n_prev            = 1'b1;
                            o_action.st_en    = 1'b1;
                            o_action.status   = ST_INVALID;
                            o_action.position = r_out_pos;
                        end else begin
                            do_end        = 1'b1;
                            if (r_out_pos == '0) begin
                                n_sync = '0;
                            end
                            n_cur         = r_out_pos;
                            n_hdr         = i_in.data_byte;
                            o_action.base = t_addr'(r_out_pos);
                            if (nal_type inside {[NAL_SINGLE_MIN:NAL_SINGLE_MAX]}) begin
                                if (small_sc) begin
                                    n_phase = PH_DONE;
                                    n_hdr   = DATA_W'(ST_SMALL);
                                end else begin
                                    n_phase          = PH_SINGLE;
                                    o_action.sc_en   = 1'b1;
                                    o_action.byte_en = 1'b1;
                                    o_action.data    = i_in.data_byte;
                                    n_cur            = r_out_pos + sc_len + t_pos'(1);
                                end
                            end else if (nal_type == NAL_STAP_A) begin
                                if (small_stap) begin
                                    n_phase = PH_DONE;
                                    n_hdr   = DATA_W'(ST_SMALL);
                                end else begin
                                    n_phase = PH_STAP_HI;
                                end
                            end else if (nal_type == NAL_FU_A) begin
                                if (small_sc) begin
                                    n_prev  = 1'b1;
                                    n_phase = PH_DONE;
                                    n_hdr   = DATA_W'(ST_SMALL);
                                end else begin
                                    n_phase = PH_FU_HDR;
                                end
                            end else begin
                                n_out_pos = '0;
                                n_phase   = PH_DONE;
                                n_hdr     = DATA_W'(ST_UNSUPPORTED);
                            end
                        end
                    end else if (r_phase != PH_IDLE) begin
                        do_end        = 1'b1;
                        n_bi          = r_bi + t_len'(1);
                        o_action.base = t_addr'(r_cur);
                        case (r_phase)
                            PH_SINGLE, PH_FU_DATA: begin
                                o_action.byte_en = 1'b1;
                                o_action.data    = i_in.data_byte;
                                n_cur            = r_cur + t_pos'(1);
                            end
                            PH_STAP_HI: begin
                                if (r_cur >= r_cap) begin
                                    n_phase = PH_DONE;
                                    n_hdr   = DATA_W'(ST_SUCCESS);
                                end else if ((t_wide'(r_cur) + t_wide'(sc_len)) >
                                             t_wide'(r_cap)) begin
                                    n_phase = PH_DONE;
                                    n_hdr   = DATA_W'(ST_INVALID);
                                end else begin
                                    o_action.sc_en = 1'b1;
                                    n_cur          = r_cur + sc_len;
                                    n_hdr          = i_in.data_byte;
                                    n_phase        = PH_STAP_LO;
                                end
                            end
                            PH_STAP_LO: begin
                                if (((t_wide'(r_cur) + t_wide'(stap_size)) > t_wide'(r_cap)) ||
                                    ((t_wide'(n_bi) + t_wide'(1) + t_wide'(stap_size)) >
                                     t_wide'(r_len))) begin
                                    n_phase = PH_DONE;
                                    n_hdr   = DATA_W'(ST_INVALID);
                                end else if (stap_size == '0) begin
                                    n_out_pos = r_cur;
                                    n_sync    = r_cur;
                                    n_phase   = PH_STAP_HI;
                                end else begin
                                    n_nal   = stap_size;
                                    n_phase = PH_STAP_DATA;
                                end
                            end
                            PH_STAP_DATA: begin
                                o_action.byte_en = 1'b1;
                                o_action.data    = i_in.data_byte;
                                n_cur            = r_cur + t_pos'(1);
                                n_nal            = r_nal - SIZE_W'(1);
                                if (n_nal == '0) begin
                                    n_out_pos = n_cur;
                                    n_sync    = n_cur;
                                    n_phase   = PH_STAP_HI;
                                end
                            end
                            PH_FU_HDR: begin
                                if ((i_in.data_byte & FU_START_BIT) != '0) begin
                                    o_action.sc_en   = 1'b1;
                                    o_action.byte_en = 1'b1;
                                    o_action.data    = (r_hdr & NRI_MASK) |
                                                       (i_in.data_byte & NAL_TYPE_MASK);
                                    n_cur            = r_cur + sc_len + t_pos'(1);
                                    n_hdr            = i_in.data_byte;
                                    n_phase          = PH_FU_DATA;
                                end else if (r_prev) begin
                                    n_phase = PH_DONE;
                                    if (r_sync > r_out_pos) begin
                                        n_hdr = DATA_W'(ST_INVALID);
                                    end else begin
                                        n_out_pos = r_sync;
                                        n_hdr     = DATA_W'(ST_IGNORED);
                                    end
                                end else begin
                                    n_hdr   = i_in.data_byte;
                                    n_phase = PH_FU_DATA;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end

        if (do_end) begin
            at_end = i_in.last || ((t_wide'(n_bi) + t_wide'(1)) >= t_wide'(n_len));
        end

        if (at_end) begin
            if (n_phase == PH_DONE) begin
                fin_st = n_hdr[STATUS_W-1:0];
            end else if ((t_wide'(n_bi) + t_wide'(1)) < t_wide'(n_len)) begin
                fin_st = ST_INVALID;
            end else if (n_phase == PH_SINGLE) begin
                n_out_pos = n_cur;
                n_sync    = n_cur;
                fin_st    = ST_SUCCESS;
            end else if (n_phase == PH_STAP_HI) begin
                fin_st = ST_SUCCESS;
            end else if (n_phase == PH_FU_DATA) begin
                n_out_pos = n_cur;
                if ((n_hdr & NRI_REF_BIT) != '0) begin
                    n_sync = n_cur;
                end
                fin_st = ST_SUCCESS;
            end else begin
                fin_st = ST_INVALID;
            end
            n_phase = PH_IDLE;
            if (fin_st == ST_SUCCESS) begin
                n_prev = 1'b0;
            end
            o_action.st_en    = 1'b1;
            o_action.status   = fin_st;
            o_action.position = n_out_pos;
        end

        o_push = o_action.sc_en || o_action.byte_en || o_action.st_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bi      <= '0;
            r_len     <= '0;
            r_nal     <= '0;
            r_hdr     <= '0;
            r_cur     <= '0;
            r_out_pos <= '0;
            r_sync    <= '0;
            r_prev    <= 1'b0;
            r_scl     <= SC_LEN_RESET;
            r_cap     <= CAP_RESET;
        end else begin
            r_phase   <= n_phase;
            r_bi      <= n_bi;
            r_len     <= n_len;
            r_nal     <= n_nal;
            r_hdr     <= n_hdr;
            r_cur     <= n_cur;
            r_out_pos <= n_out_pos;
            r_sync    <= n_sync;
            r_prev    <= n_prev;
            if (i_cfg.valid) begin
                case (i_cfg.addr)
                    CFG_START_CODE_LEN: r_scl <= i_cfg.wdata[SCL_W-1:0];
                    CFG_OUT_CAPACITY:   r_cap <= i_cfg.wdata;
                    default: ;
                endcase
            end
        end
    end

    a_cmd_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.cmd != CMD_BYTE)) |-> !o_push)
        else $error("command transaction produced results");

    a_status_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_action.st_en) |=> (r_phase == PH_IDLE))
        else $error("payload status issued while parse still active");

endmodule

// ===== design/h264dp_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h264dp_queue
// Small FIFO of action records between the front end and the back end.
// ============================================================================
module h264dp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  h264dp_pkg::t_action  i_push_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_head_valid,
    output h264dp_pkg::t_action  o_head
);
    import h264dp_pkg::*;

    t_action             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_count;

    assign o_full       = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");

endmodule

// ===== design/h264dp_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h264dp_back
// Back end: expands each action record into its buffer writes and payload status,
// if any, one result per cycle unless o_out stalls, through a registered output stage.
// ============================================================================
module h264dp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  h264dp_pkg::t_action  i_head,
    output logic                 o_pop,
    h264dp_out_if.source         o_out
);
    import h264dp_pkg::*;

    typedef struct packed {
        logic                 kind;
        t_addr                write_addr;
        logic [DATA_W-1:0]    write_data;
        logic [STATUS_W-1:0]  status;
        t_pos                 position;
        logic                 final_res;
    } t_result;

    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    t_result           r_res;
    t_result           n_res;

    logic [STEP_W-1:0] sc_cnt;
    logic [STEP_W-1:0] total;
    logic              last_step;
    logic              fire;

    assign sc_cnt    = i_head.sc_en ? (i_head.sc_four ? STEP_W'(4) : STEP_W'(3)) : '0;
    assign total     = sc_cnt + STEP_W'(i_head.byte_en) + STEP_W'(i_head.st_en);
    assign last_step = ((r_step + STEP_W'(1)) == total);
    assign fire      = i_head_valid && (!r_valid || o_out.ready);
    assign o_pop     = fire && last_step;

    always_comb begin
        n_res = '0;
        if (r_step < sc_cnt) begin
            n_res.kind       = KIND_WRITE;
            n_res.write_addr = i_head.base + t_addr'(r_step);
            n_res.write_data = (r_step == (sc_cnt - STEP_W'(1))) ? SC_LAST_BYTE : SC_ZERO_BYTE;
        end else if ((r_step == sc_cnt) && i_head.byte_en) begin
            n_res.kind       = KIND_WRITE;
            n_res.write_addr = i_head.base + t_addr'(r_step);
            n_res.write_data = i_head.data;
        end else begin
            n_res.kind     = KIND_STATUS;
            n_res.status   = i_head.status;
            n_res.position = i_head.position;
        end
        n_res.final_res = last_step;
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                r_step  <= last_step ? '0 : (r_step + STEP_W'(1));
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.kind       = r_res.kind;
    assign o_out.write_addr = r_res.write_addr;
    assign o_out.write_data = r_res.write_data;
    assign o_out.status     = r_res.status;
    assign o_out.position   = r_res.position;
    assign o_out.final_res  = r_res.final_res;

    a_status_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.kind == KIND_STATUS)) |-> r_res.final_res)
        else $error("payload status not marked as last result");

endmodule
